// ===== sv/video_unit_register_port_assert.svh =====
// Assertion macros for the video register port checker.
`ifndef VIDEO_UNIT_REGISTER_PORT_ASSERT_SVH
`define VIDEO_UNIT_REGISTER_PORT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define VRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define VRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/vurp_pkg.sv =====
// Shared types and constants of the video register port.
package vurp_pkg;
  localparam int unsigned DotsPerLineDef = 341;
  localparam int unsigned PrerenderLineDef = 261;
  localparam logic [8:0] VblankLine = 9'd241;

  localparam logic [1:0] FuncTick = 2'd0;
  localparam logic [1:0] FuncRead = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;

  localparam logic [2:0] RegControl = 3'd0;
  localparam logic [2:0] RegStatus = 3'd2;
  localparam logic [2:0] RegScroll = 3'd5;
  localparam logic [2:0] RegAddress = 3'd6;
  localparam logic [2:0] RegData = 3'd7;

  // One classified request, handed from front to back.
  typedef struct packed {
    logic [1:0] func;
    logic [2:0] reg_sel;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi;
    logic       vblank;
  } res_t;
endpackage

// ===== sv/video_unit_register_port.sv =====
// Top level of the video unit register port.
// Register port and frame timing of a console video unit. Each request on the slave stream
// is a dot tick, a register read or a register write; each yields one result on the master
// stream with the read byte, the NMI pulse and the vblank flag. Requests pass a front
// register slice and a two-entry queue to the back end, which holds all register state,
// the 8 KiB pattern RAM, the 2 KiB nametable RAM and the palette. One request is taken per
// clock while the back end is not clearing its RAMs and the master side does not stall it;
// the back end carries out each request as it takes it, and the RAM byte of a buffered
// data read is folded into the read buffer on the following cycle while the next request
// proceeds. A result passes the front register, the queue and the back-end output register;
// with the master side stalled, up to four requests are held inside before the slave side
// stalls. After reset the back end clears its RAMs and takes no request meanwhile. Nametable
// mirroring is set by cfg_we_i/cfg_wdata_i while idle; the user keeps to this, the block does not check.
module video_unit_register_port
  import vurp_pkg::*;
#(
  parameter int unsigned DotsPerLine = DotsPerLineDef,
  parameter int unsigned PrerenderLine = PrerenderLineDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // mirror_horizontal
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,         // [2:0] reg_sel, [10:3] write_data
  input  logic [1:0]  s_tuser,         // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata          // [7:0] read_data, [8] nmi, [9] vblank
);
  logic mirror_q;
  logic f_valid, f_ready, b_valid, b_ready;
  req_t f_req, b_req;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mirror_q <= 1'b0;
    else if (cfg_we_i) mirror_q <= cfg_wdata_i;
  end

  // Register the incoming request; reg_sel and write_data sit in tdata.
  vurp_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .s_tdata_i(s_tdata[10:0]), .s_tuser_i(s_tuser),
    .req_valid_o(f_valid), .req_ready_i(f_ready), .req_o(f_req)
  );

  vurp_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_req_i(f_req),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_req_o(b_req)
  );

  vurp_back #(.DotsPerLine(DotsPerLine), .PrerenderLine(PrerenderLine)) u_back (
    .clk_i, .rst_ni, .mirror_horizontal_i(mirror_q),
    .req_valid_i(b_valid), .req_ready_o(b_ready), .req_i(b_req),
    .res_valid_o(m_tvalid), .res_ready_i(m_tready), .res_o(res)
  );

  assign m_tdata = {6'd0, res.vblank, res.nmi, res.read_data};
endmodule

// ===== sv/vurp_queue.sv =====
// Two-entry request queue between the front and the back.
module vurp_queue
  import vurp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output req_t out_req_o
);
  req_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_req_o   = mem_q[rptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== sv/vurp_back.sv =====
// Back end: register state, frame timing and the video stores.
module vurp_back
  import vurp_pkg::*;
#(
  parameter int unsigned DotsPerLine = DotsPerLineDef,
  parameter int unsigned PrerenderLine = PrerenderLineDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic mirror_horizontal_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);
  localparam int unsigned PtClrDepth = 8192;
  localparam int unsigned NtClrDepth = 2048;

  logic [7:0]  control_q;
  logic        vblank_q, toggle_q;
  logic [15:0] temp_q, vaddr_q;
  logic [7:0]  rbuf_q;
  logic [8:0]  dot_q, line_q;
  logic [7:0]  pal_q [32];
  logic [31:0] pal_vld_q;
  logic [7:0]  pt_mem [PtClrDepth];
  logic [7:0]  nt_mem [NtClrDepth];
  logic [13:0] clr_q;
  logic        clr_busy_q;

  // Output stage plus a flag that reloads the buffer from RAM data.
  logic        out_valid_q;
  res_t        out_q;
  logic        rd_pend_q;   // RAM data of last cycle goes into the buffer
  logic        rd_pt_q;
  logic [7:0]  pt_rd_q, nt_rd_q;

  logic        take;
  logic        buf_rd;
  logic [7:0]  ram_rd;
  logic [13:0] bus_a;
  logic [10:0] nt_idx;
  logic        is_pt, is_nt, is_pal;
  logic [8:0]  dot_inc;
  logic        ram_wr_pt, ram_wr_nt;

  assign bus_a  = vaddr_q[13:0];
  assign is_pt  = bus_a <= 14'h1FFF;
  assign is_nt  = !is_pt && bus_a <= 14'h3EFF;
  assign is_pal = !is_pt && !is_nt;
  assign nt_idx = {mirror_horizontal_i ? bus_a[11] : bus_a[10], bus_a[9:0]};

  assign req_ready_o = !clr_busy_q && (!out_valid_q || res_ready_i);
  assign take = req_valid_i && req_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

  // Buffered data read: old buffer goes out, RAM byte lands next cycle.
  assign buf_rd = take && req_i.func == FuncRead && req_i.reg_sel == RegData && !is_pal;
  assign ram_rd = rd_pt_q ? pt_rd_q : nt_rd_q;

  assign ram_wr_pt = take && req_i.func == FuncWrite && req_i.reg_sel == RegData && is_pt;
  assign ram_wr_nt = take && req_i.func == FuncWrite && req_i.reg_sel == RegData && is_nt;

  // Clear the RAMs after reset, one entry a cycle.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      pt_mem[clr_q[12:0]] <= 8'h00;
      nt_mem[clr_q[10:0]] <= 8'h00;
    end else begin
      if (ram_wr_pt) pt_mem[bus_a[12:0]] <= req_i.write_data;
      if (ram_wr_nt) nt_mem[nt_idx] <= req_i.write_data;
    end
    pt_rd_q <= pt_mem[bus_a[12:0]];
    nt_rd_q <= nt_mem[nt_idx];
  end

  always_ff @(posedge clk_i) begin
    if (take && req_i.func == FuncWrite && req_i.reg_sel == RegData && is_pal) begin
      pal_q[bus_a[4:0]] <= req_i.write_data;
    end
  end

  assign dot_inc = dot_q + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= '0; vblank_q <= 1'b0; toggle_q <= 1'b0;
      temp_q <= '0; vaddr_q <= '0; rbuf_q <= '0;
      dot_q <= '0; line_q <= 9'(PrerenderLine);
      pal_vld_q <= '0; clr_q <= '0; clr_busy_q <= 1'b1;
      out_valid_q <= 1'b0; out_q <= '0; rd_pend_q <= 1'b0;
      rd_pt_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_q <= clr_q + 14'd1;
        if (clr_q == 14'(PtClrDepth - 1)) clr_busy_q <= 1'b0;
      end
      // Fold the RAM read of last cycle into the buffer.
      rd_pend_q <= buf_rd;
      if (buf_rd) rd_pt_q <= is_pt;
      if (rd_pend_q) begin
        rbuf_q <= ram_rd;
      end
      out_valid_q <= take || (out_valid_q && !res_ready_i);
      if (take) begin
        logic [7:0] rd;
        logic       nmi, vb;
        rd = 8'h00; nmi = 1'b0; vb = vblank_q;
        unique case (req_i.func)
          FuncTick: begin
            if (line_q == VblankLine && dot_q == 9'd1) begin
              vb = 1'b1; nmi = control_q[7];
            end else if (line_q == 9'(PrerenderLine) && dot_q == 9'd1) begin
              vb = 1'b0;
            end
            if (dot_inc >= 9'(DotsPerLine) || dot_inc == 9'd0) begin
              dot_q <= '0;
              line_q <= (line_q >= 9'(PrerenderLine)) ? 9'd0 : line_q + 9'd1;
            end else begin
              dot_q <= dot_inc;
            end
          end
          FuncRead: begin
            if (req_i.reg_sel == RegStatus) begin
              rd = {vblank_q, 7'd0}; vb = 1'b0; toggle_q <= 1'b0;
            end else if (req_i.reg_sel == RegData) begin
              vaddr_q <= vaddr_q + (control_q[2] ? 16'd32 : 16'd1);
              if (is_pal) begin
                rd = pal_vld_q[bus_a[4:0]] ? {3'b000, pal_q[bus_a[4:0]][4:0]} : 8'h00;
              end else begin
                rd = rd_pend_q ? ram_rd : rbuf_q;
              end
            end
          end
          FuncWrite: begin
            priority if (req_i.reg_sel == RegControl) begin
              control_q <= req_i.write_data;
            end else if (req_i.reg_sel == RegScroll) begin
              toggle_q <= ~toggle_q;
            end else if (req_i.reg_sel == RegAddress) begin
              toggle_q <= ~toggle_q;
              if (!toggle_q) begin
                temp_q <= {2'b00, req_i.write_data[5:0], temp_q[7:0]};
              end else begin
                temp_q <= {temp_q[15:8], req_i.write_data};
                vaddr_q <= {temp_q[15:8], req_i.write_data};
              end
            end else if (req_i.reg_sel == RegData) begin
              vaddr_q <= vaddr_q + (control_q[2] ? 16'd32 : 16'd1);
              if (is_pal) pal_vld_q[bus_a[4:0]] <= 1'b1;
            end else begin
            end
          end
          default: begin
          end
        endcase
        vblank_q <= vb;
        out_q <= '{read_data: rd, nmi: nmi, vblank: vb};
      end
    end
  end
endmodule

// ===== sv/vurp_front.sv =====
// Front end: input register slice that accepts and packs requests.
module vurp_front
  import vurp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [10:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  output logic        req_valid_o,
  input  logic        req_ready_i,
  output req_t        req_o
);
  logic valid_q;
  req_t req_q;

  assign s_tready_o  = !valid_q || req_ready_i;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      req_q <= '{func: s_tuser_i, reg_sel: s_tdata_i[2:0], write_data: s_tdata_i[10:3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_tready_o) begin
      valid_q <= s_tvalid_i;
    end
  end
endmodule

// ===== sv/vurp_checker.sv =====
// Port-level checker for the video register port, bound to the top level.
`include "video_unit_register_port_assert.svh"
module vurp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  `VRP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready, m_tvalid)
  `VRP_ASSERT_IMP(a_nmi_vb, clk_i, rst_ni, m_tvalid && m_tdata[8], m_tdata[9])
  `VRP_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_tvalid, m_tdata[15:10] == 6'd0)
endmodule

bind video_unit_register_port vurp_checker u_checker (
  .clk_i, .rst_ni, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
